### rtl/kpsd_pkg.sv
// Shared types and constants of the keypad scan, debounce and auto-repeat block.
// Holds register codes, field widths and the per-key state record.
// No dependencies.
package kpsd_pkg;

  // Fixed field widths
  localparam int KEY_W      = 5;
  localparam int SIDE_W     = 5;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int ROW_SEL_W  = 2;
  localparam int OUT_DATA_W = 16;

  // Configuration register codes
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_DB    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DB  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FIRST  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_REPEAT = 8'd3;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] PRESS_DB_RST    = 16'd50;
  localparam logic [CFG_W-1:0] RELEASE_DB_RST  = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_FIRST_RST  = 16'd800;
  localparam logic [CFG_W-1:0] HOLD_REPEAT_RST = 16'd200;

  localparam logic [CFG_W-1:0] HOLD_MAX = 16'hFFFF;

  typedef struct packed {
    logic [CFG_W-1:0] press_db;
    logic [CFG_W-1:0] release_db;
    logic [CFG_W-1:0] hold_first;
    logic [CFG_W-1:0] hold_repeat;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] press_stamp;
    logic [TIME_W-1:0] release_stamp;
    logic              armed;
    logic [CFG_W-1:0]  count;
  } key_state_t;

  // Report changes requested by one key step
  typedef struct packed {
    logic grab;       // debounced press: take over the reported key
    logic hold_fire;  // first or repeated hold
    logic drop;       // debounced release of the reported key
  } key_flags_t;

endpackage

### rtl/kpsd_row_collect.sv
// Row cursor and scan buffer: collects column reads row by row and builds the
// active-high key image on the last row. Depends on kpsd_pkg.
module kpsd_row_collect #(
  parameter int NUM_KEYS = 17,
  parameter int NUM_ROWS = 3,
  parameter int NUM_COLS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [NUM_COLS-1:0]            cols,
  input  logic [kpsd_pkg::SIDE_W-1:0]    side,
  output logic                           last_row,
  output logic [NUM_KEYS-1:0]            image,
  output logic [kpsd_pkg::ROW_SEL_W-1:0] row_sel
);
  import kpsd_pkg::*;

  localparam int BUF_W  = NUM_ROWS * NUM_COLS;
  localparam int RAW_W  = BUF_W + SIDE_W;
  localparam int FULL_W = (RAW_W > NUM_KEYS) ? RAW_W : NUM_KEYS;
  localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  logic [ROW_W-1:0]           cursor_r, cursor_nxt;
  logic [BUF_W-1:0]           scan_buf_r, scan_buf_nxt;
  logic [RAW_W-1:0]           raw;
  logic [FULL_W-1:0]          raw_full;
  logic [ROW_W+ROW_SEL_W-1:0] cursor_ext;

  // Merge this row into the buffer; the first row starts a fresh scan
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (cursor_r == ROW_W'(r)) begin
        scan_buf_nxt[r*NUM_COLS +: NUM_COLS] = cols;
      end else if (cursor_r == '0) begin
        scan_buf_nxt[r*NUM_COLS +: NUM_COLS] = '0;
      end else begin
        scan_buf_nxt[r*NUM_COLS +: NUM_COLS] = scan_buf_r[r*NUM_COLS +: NUM_COLS];
      end
    end
  end

  // Advance the row cursor, wrap after the last row
  assign last_row   = (cursor_r == ROW_W'(NUM_ROWS - 1));
  assign cursor_nxt = last_row ? '0 : cursor_r + 1'b1;

  // Side buttons sit above the matrix; missing bits are zero-filled and read as pressed lines
  assign raw      = {side, scan_buf_nxt};
  assign raw_full = FULL_W'(raw);
  assign image    = ~raw_full[NUM_KEYS-1:0];

  assign cursor_ext = (ROW_W + ROW_SEL_W)'(cursor_r);
  assign row_sel    = cursor_ext[ROW_SEL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r   <= '0;
      scan_buf_r <= '0;
    end else if (accept) begin
      cursor_r   <= cursor_nxt;
      scan_buf_r <= scan_buf_nxt;
    end
  end

endmodule

### rtl/kpsd_key_unit.sv
// Shared per-key update unit: debounce compares, hold counting and the
// release check for the one key the sequencer selects. Depends on kpsd_pkg.
module kpsd_key_unit (
  input  logic                        was_down,
  input  logic                        is_down,
  input  logic                        pause,
  input  logic [kpsd_pkg::TIME_W-1:0] now,
  input  kpsd_pkg::cfg_t              cfg,
  input  logic                        cur_match,
  input  kpsd_pkg::key_state_t        st_in,
  output kpsd_pkg::key_state_t        st_out,
  output kpsd_pkg::key_flags_t        flags
);
  import kpsd_pkg::*;

  logic [TIME_W-1:0] press_age;
  logic [TIME_W-1:0] release_age;
  logic              press_ok;
  logic              release_ok;
  logic [CFG_W-1:0]  count_inc;
  logic [CFG_W-1:0]  reload;
  logic              armed_new;

  // Wrapping ages of the last press and release
  assign press_age   = now - st_in.press_stamp;
  assign release_age = now - st_in.release_stamp;
  assign press_ok    = press_age > TIME_W'(cfg.press_db);
  assign release_ok  = release_age > TIME_W'(cfg.release_db);

  // Repeat reload saturates at zero
  assign reload = (cfg.hold_repeat > cfg.hold_first) ? '0
                                                     : cfg.hold_first - cfg.hold_repeat;

  always_comb begin
    st_out    = st_in;
    flags     = '0;
    armed_new = st_in.armed;
    count_inc = st_in.count;

    // Edge, press and hold handling only while at most one key is down
    if (!pause) begin
      if (!was_down && is_down) begin
        st_out.press_stamp = now;
      end
      if (was_down && !is_down) begin
        st_out.release_stamp = now;
      end
      if (was_down && is_down) begin
        if (press_ok && !st_in.armed) begin
          flags.grab = 1'b1;
          armed_new  = 1'b1;
        end
        if (armed_new && st_in.count != HOLD_MAX) begin
          count_inc = st_in.count + 1'b1;
        end
        st_out.armed = armed_new;
        st_out.count = count_inc;
        if (count_inc == cfg.hold_first) begin
          flags.hold_fire = 1'b1;
          st_out.count    = reload;
        end
      end
    end

    // Debounced release disarms the key and drops it if it is reported
    if (!was_down && !is_down && release_ok) begin
      flags.drop   = cur_match;
      st_out.armed = 1'b0;
      st_out.count = '0;
    end
  end

endmodule

### rtl/keypad_scan_debounce_repeat_core.sv
// Top level of the keypad scanner with per-key debounce and auto-repeat.
// Uses kpsd_pkg, kpsd_row_collect and kpsd_key_unit.
// Usage: one request on the in_ channel per 1 ms tick carries the column reads
//   of the row driven during the tick, the five side buttons and the ms time.
//   Each request gives one result on the out_ channel: the row to drive next,
//   the reported key and its levels, and press/hold pulses; out_tlast marks
//   the tick that finished a scan. The cfg_ channel writes the four timing
//   registers; it is always ready and must only be used while the block is idle.
// Sequence: a tick on a row other than the last goes from the idle state straight to
//   the emit state, which loads its result into the output register, and the next request is taken back in idle.
//   A last-row tick walks all NUM_KEYS keys through the shared key update unit,
//   one key per cycle, before the emit state loads its result; the next request
//   is taken only once the block is back in idle. in_tready is low meanwhile.
// Reset: synchronous, active low; row 0 is selected, all per-key state and
//   the report are cleared and the registers return to 50, 50, 800, 200.
// Stall: the result waits in the output register; one following request is
//   still taken and processed, and its result waits until the register is free.
module keypad_scan_debounce_repeat_core #(
  parameter int NUM_KEYS = 17,
  parameter int NUM_ROWS = 3,
  parameter int NUM_COLS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: column_lines [NUM_COLS-1:0], side_buttons [+5], now_ms [+32], zero pad
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [((NUM_COLS+37+7)/8)*8-1:0] in_tdata,
  // out_tdata: row_select [1:0], key_valid [2], key_code [7:3], key_pressed [8],
  //            key_held [9], press_event [10], hold_event [11], zero pad [15:12]
  // out_tlast: scan_done
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kpsd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpsd_pkg::CFG_W-1:0]      cfg_data
);
  import kpsd_pkg::*;

  localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state_r;
  logic [KIDX_W-1:0]      idx_r;
  logic [NUM_KEYS-1:0]    prev_r;
  logic [NUM_KEYS-1:0]    actual_r;
  logic                   pause_r;
  logic [TIME_W-1:0]      now_r;
  logic                   done_r;
  logic [KEY_W-1:0]       cur_r;
  logic                   valid_r;
  logic                   pressed_r;
  logic                   held_r;
  logic                   pev_r;
  logic                   hev_r;
  cfg_t                   cfg_r;
  key_state_t             ks_r [NUM_KEYS];
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic                   out_last_r;

  logic                   in_acc;
  logic                   out_load;
  logic [NUM_COLS-1:0]    in_cols;
  logic [SIDE_W-1:0]      in_side;
  logic [TIME_W-1:0]      in_now;
  logic                   last_row;
  logic [NUM_KEYS-1:0]    image;
  logic                   pause_nxt;
  logic [ROW_SEL_W-1:0]   row_sel;
  logic                   last_key;
  logic                   cur_match;
  key_state_t             st_out;
  key_flags_t             flags;
  logic [KEY_W-1:0]       code_out;
  logic [OUT_DATA_W-1:0]  out_data_nxt;

  // Unpack the request
  assign in_cols = in_tdata[NUM_COLS-1:0];
  assign in_side = in_tdata[NUM_COLS +: SIDE_W];
  assign in_now  = in_tdata[NUM_COLS+SIDE_W +: TIME_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  kpsd_row_collect #(
    .NUM_KEYS (NUM_KEYS),
    .NUM_ROWS (NUM_ROWS),
    .NUM_COLS (NUM_COLS)
  ) u_rows (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .cols     (in_cols),
    .side     (in_side),
    .last_row (last_row),
    .image    (image),
    .row_sel  (row_sel)
  );

  // Two or more keys down: clearing the lowest set bit leaves something
  assign pause_nxt = (image & (image - 1'b1)) != '0;

  // Shared key update for the key under the walk index
  assign last_key  = (idx_r == KIDX_W'(NUM_KEYS - 1));
  assign cur_match = valid_r && (cur_r == KEY_W'(idx_r));

  kpsd_key_unit u_key (
    .was_down  (prev_r[idx_r]),
    .is_down   (actual_r[idx_r]),
    .pause     (pause_r),
    .now       (now_r),
    .cfg       (cfg_r),
    .cur_match (cur_match),
    .st_in     (ks_r[idx_r]),
    .st_out    (st_out),
    .flags     (flags)
  );

  // Result word
  assign code_out     = valid_r ? cur_r : '0;
  assign out_data_nxt = {4'b0000, hev_r, pev_r, held_r, pressed_r, code_out, valid_r,
                         row_sel};
  assign out_load     = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  // Sequencer: take a tick, walk the keys on a finished scan, emit the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      prev_r    <= '0;
      done_r    <= 1'b0;
      cur_r     <= '0;
      valid_r   <= 1'b0;
      pressed_r <= 1'b0;
      held_r    <= 1'b0;
      pev_r     <= 1'b0;
      hev_r     <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        ks_r[k] <= '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            actual_r <= image;
            pause_r  <= pause_nxt;
            now_r    <= in_now;
            done_r   <= last_row;
            pev_r    <= 1'b0;
            hev_r    <= 1'b0;
            idx_r    <= '0;
            state_r  <= last_row ? ST_WALK : ST_EMIT;
          end
        end
        ST_WALK: begin
          ks_r[idx_r] <= st_out;
          if (flags.grab) begin
            cur_r     <= KEY_W'(idx_r);
            valid_r   <= 1'b1;
            pressed_r <= 1'b1;
            pev_r     <= 1'b1;
          end
          if (flags.hold_fire) begin
            held_r <= 1'b1;
            hev_r  <= 1'b1;
          end
          if (flags.drop) begin
            cur_r     <= '0;
            valid_r   <= 1'b0;
            pressed_r <= 1'b0;
            held_r    <= 1'b0;
          end
          if (last_key) begin
            prev_r  <= actual_r;
            state_r <= ST_EMIT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_last_r <= done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_db    <= PRESS_DB_RST;
      cfg_r.release_db  <= RELEASE_DB_RST;
      cfg_r.hold_first  <= HOLD_FIRST_RST;
      cfg_r.hold_repeat <= HOLD_REPEAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRESS_DB:    cfg_r.press_db    <= cfg_data;
        REG_RELEASE_DB:  cfg_r.release_db  <= cfg_data;
        REG_HOLD_FIRST:  cfg_r.hold_first  <= cfg_data;
        REG_HOLD_REPEAT: cfg_r.hold_repeat <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A press pulse always comes with the pressed key reported
  a_press_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && pev_r |=> out_tdata[2] && out_tdata[8])
    else $error("press event without a reported pressed key");

  // Event pulses only appear on ticks that finished a scan
  a_events_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (pev_r || hev_r) |-> done_r)
    else $error("event pulse on a tick without a scan");

  // Leaving the walk stores the analysed image as the previous scan
  a_walk_commit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && last_key |=> state_r == ST_EMIT && prev_r == actual_r)
    else $error("walk finished without committing the key image");

  // No request is taken while a tick is still being processed
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && !last_key |=> !in_acc && state_r == ST_WALK)
    else $error("request taken during the key walk");

endmodule
